// ===== sv/nrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC line parser package
// Shared widths, character codes, result codes and scanner types.
// ----------------------------------------------------------------------------
package nrlp_pkg;

  localparam int LINE_CHARS_DEF = 128;
  localparam int VAL_W          = 18;
  localparam int ACC_W          = 22;
  localparam int CNT_W          = 5;
  localparam int HEAD_W         = 4;
  localparam int NUM_LIMIT      = 99999;
  localparam int COMMA_CAP      = 19;
  localparam int HEAD_LEN       = 6;
  localparam int HEAD_FAIL      = 15;
  localparam int MIN_COMMAS     = 6;

  localparam int FIELD_HEAD     = 0;
  localparam int FIELD_STATUS   = 2;
  localparam int FIELD_LAT      = 3;
  localparam int FIELD_LAT_DIR  = 4;
  localparam int FIELD_LON      = 5;
  localparam int FIELD_LON_DIR  = 6;

  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_PRINT_MIN = 8'd32;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_LOCK      = 8'h41;

  typedef enum logic [1:0] {
    CLS_IGNORED,
    CLS_NO_FIX,
    CLS_FIX
  } line_class_t;

  typedef enum logic [1:0] {
    FIX_NONE,
    FIX_NOT_LOCKED,
    FIX_LOCKED
  } fix_state_t;

  typedef enum logic [1:0] {
    PH_SPACES,
    PH_POS,
    PH_NEG,
    PH_STOPPED
  } num_phase_t;

  typedef struct packed {
    num_phase_t              phase;
    logic signed [VAL_W-1:0] acc;
  } num_scan_t;

  function automatic logic [7:0] head_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/nmea_rmc_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC line parser core
// Parses GPS receiver bytes on the fly and reports the fix at each line end.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle unless held off and never
// stores the line: each beat is registered in the input byte register and then
// folded into the running parse state; the result beat is registered when the
// carriage return that ends the line is folded in. Input is held off only when a
// carriage return finds the result register still occupied. Each result carries
// the line class and the current fix state with the last locked position.
module nmea_rmc_line_parser_core #(
  parameter int LINE_CHARS = nrlp_pkg::LINE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // fix_state[1:0], latitude_ddmm[19:2],
                                  // latitude_hemisphere[27:20],
                                  // longitude_dddmm[45:28],
                                  // longitude_hemisphere[53:46], zero[55:54]
  output logic [1:0]  out_tuser   // line_class[1:0]
);

  localparam int LEN_W = $clog2(LINE_CHARS);
  localparam int VW    = nrlp_pkg::VAL_W;
  localparam int CW    = nrlp_pkg::CNT_W;

  logic                 in_valid_r, in_valid_nxt;
  logic [7:0]           byte_r;
  logic                 is_cr, is_print, advance;

  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [CW-1:0]        comma_r, comma_nxt;
  logic [3:0]           head_r, head_nxt;
  logic [7:0]           status_r, status_nxt;
  nrlp_pkg::num_phase_t phase_r, phase_nxt;
  logic signed [VW-1:0] new_lat_r, new_lat_nxt;
  logic signed [VW-1:0] new_lon_r, new_lon_nxt;
  logic [7:0]           new_lat_dir_r, new_lat_dir_nxt;
  logic [7:0]           new_lon_dir_r, new_lon_dir_nxt;
  nrlp_pkg::fix_state_t gps_r, gps_nxt;
  logic signed [VW-1:0] held_lat_r, held_lat_nxt;
  logic signed [VW-1:0] held_lon_r, held_lon_nxt;
  logic [7:0]           held_lat_dir_r, held_lat_dir_nxt;
  logic [7:0]           held_lon_dir_r, held_lon_dir_nxt;
  nrlp_pkg::line_class_t cls;

  logic                 out_valid_r, out_valid_nxt;
  logic [55:0]          out_data_r;
  logic [1:0]           out_user_r;

  nrlp_pkg::num_scan_t  scan_in, scan_out;

  assign is_cr    = (byte_r == nrlp_pkg::CHAR_CR);
  assign is_print = (byte_r >= nrlp_pkg::CHAR_PRINT_MIN);
  assign advance  = in_valid_r && (!is_cr || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign scan_in.phase = phase_r;
  assign scan_in.acc   = (comma_r == CW'(nrlp_pkg::FIELD_LAT)) ? new_lat_r : new_lon_r;

  nrlp_num_scan u_num_scan (
    .scan_i (scan_in),
    .char_i (byte_r),
    .scan_o (scan_out)
  );

  always_comb begin
    in_valid_nxt     = in_tready ? in_tvalid : in_valid_r;
    len_nxt          = len_r;
    comma_nxt        = comma_r;
    head_nxt         = head_r;
    status_nxt       = status_r;
    phase_nxt        = phase_r;
    new_lat_nxt      = new_lat_r;
    new_lon_nxt      = new_lon_r;
    new_lat_dir_nxt  = new_lat_dir_r;
    new_lon_dir_nxt  = new_lon_dir_r;
    gps_nxt          = gps_r;
    held_lat_nxt     = held_lat_r;
    held_lon_nxt     = held_lon_r;
    held_lat_dir_nxt = held_lat_dir_r;
    held_lon_dir_nxt = held_lon_dir_r;
    cls              = nrlp_pkg::CLS_IGNORED;

    if (is_print && len_r < LEN_W'(LINE_CHARS - 1)) begin
      len_nxt = len_r + LEN_W'(1);
      if (byte_r == nrlp_pkg::CHAR_COMMA) begin
        if (comma_r < CW'(nrlp_pkg::COMMA_CAP)) begin
          comma_nxt = comma_r + CW'(1);
        end
        phase_nxt = nrlp_pkg::PH_SPACES;
      end else begin
        case (comma_r)
          CW'(nrlp_pkg::FIELD_HEAD): begin
            if (head_r < 4'(nrlp_pkg::HEAD_LEN) &&
                byte_r == nrlp_pkg::head_char(head_r[2:0])) begin
              head_nxt = head_r + 4'd1;
            end else begin
              head_nxt = 4'(nrlp_pkg::HEAD_FAIL);
            end
          end
          CW'(nrlp_pkg::FIELD_STATUS): begin
            if (status_r == 8'd0) begin
              status_nxt = byte_r;
            end
          end
          CW'(nrlp_pkg::FIELD_LAT): begin
            phase_nxt   = scan_out.phase;
            new_lat_nxt = scan_out.acc;
          end
          CW'(nrlp_pkg::FIELD_LAT_DIR): begin
            if (new_lat_dir_r == 8'd0) begin
              new_lat_dir_nxt = byte_r;
            end
          end
          CW'(nrlp_pkg::FIELD_LON): begin
            phase_nxt   = scan_out.phase;
            new_lon_nxt = scan_out.acc;
          end
          CW'(nrlp_pkg::FIELD_LON_DIR): begin
            if (new_lon_dir_r == 8'd0) begin
              new_lon_dir_nxt = byte_r;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (is_cr) begin
      if (head_r == 4'(nrlp_pkg::HEAD_LEN) && comma_r >= CW'(nrlp_pkg::MIN_COMMAS)) begin
        if (status_r == nrlp_pkg::CHAR_LOCK) begin
          cls              = nrlp_pkg::CLS_FIX;
          gps_nxt          = nrlp_pkg::FIX_LOCKED;
          held_lat_nxt     = new_lat_r;
          held_lon_nxt     = new_lon_r;
          held_lat_dir_nxt = new_lat_dir_r;
          held_lon_dir_nxt = new_lon_dir_r;
        end else begin
          cls     = nrlp_pkg::CLS_NO_FIX;
          gps_nxt = nrlp_pkg::FIX_NOT_LOCKED;
        end
      end
      len_nxt         = '0;
      comma_nxt       = '0;
      head_nxt        = '0;
      status_nxt      = '0;
      phase_nxt       = nrlp_pkg::PH_SPACES;
      new_lat_nxt     = '0;
      new_lon_nxt     = '0;
      new_lat_dir_nxt = '0;
      new_lon_dir_nxt = '0;
    end

    if (advance && is_cr) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      len_r          <= '0;
      comma_r        <= '0;
      head_r         <= '0;
      status_r       <= '0;
      phase_r        <= nrlp_pkg::PH_SPACES;
      new_lat_r      <= '0;
      new_lon_r      <= '0;
      new_lat_dir_r  <= '0;
      new_lon_dir_r  <= '0;
      gps_r          <= nrlp_pkg::FIX_NONE;
      held_lat_r     <= '0;
      held_lon_r     <= '0;
      held_lat_dir_r <= '0;
      held_lon_dir_r <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        len_r          <= len_nxt;
        comma_r        <= comma_nxt;
        head_r         <= head_nxt;
        status_r       <= status_nxt;
        phase_r        <= phase_nxt;
        new_lat_r      <= new_lat_nxt;
        new_lon_r      <= new_lon_nxt;
        new_lat_dir_r  <= new_lat_dir_nxt;
        new_lon_dir_r  <= new_lon_dir_nxt;
        gps_r          <= gps_nxt;
        held_lat_r     <= held_lat_nxt;
        held_lon_r     <= held_lon_nxt;
        held_lat_dir_r <= held_lat_dir_nxt;
        held_lon_dir_r <= held_lon_dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
    if (advance && is_cr) begin
      out_user_r <= cls;
      out_data_r <= {2'b00, held_lon_dir_nxt, held_lon_nxt, held_lat_dir_nxt,
                     held_lat_nxt, gps_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_fix_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == nrlp_pkg::CLS_FIX |-> out_tdata[1:0] == nrlp_pkg::FIX_LOCKED)
    else $error("fix result without locked state");

  a_nofix_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == nrlp_pkg::CLS_NO_FIX |->
      out_tdata[1:0] == nrlp_pkg::FIX_NOT_LOCKED)
    else $error("no-fix result with wrong state");

  a_comma_cap: assert property (@(posedge clk) disable iff (!rst_n)
    comma_r <= CW'(nrlp_pkg::COMMA_CAP))
    else $error("comma count beyond cap");

  a_cr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_cr |=> len_r == '0 && comma_r == '0 && head_r == '0)
    else $error("line state not cleared at line end");

endmodule

// ===== sv/nrlp_num_scan.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC integer scanner
// One character step of a saturating leading-space, sign and digit scan.
// ----------------------------------------------------------------------------
module nrlp_num_scan (
  input  nrlp_pkg::num_scan_t scan_i,
  input  logic [7:0]          char_i,
  output nrlp_pkg::num_scan_t scan_o
);

  logic                                is_digit;
  logic [3:0]                          digit;
  logic signed [nrlp_pkg::ACC_W-1:0]   acc_ext;
  logic signed [nrlp_pkg::ACC_W-1:0]   acc10;
  logic signed [nrlp_pkg::ACC_W-1:0]   sum_pos;
  logic signed [nrlp_pkg::ACC_W-1:0]   sum_neg;

  localparam logic signed [nrlp_pkg::ACC_W-1:0] LIM_POS =
    nrlp_pkg::ACC_W'(nrlp_pkg::NUM_LIMIT);
  localparam logic signed [nrlp_pkg::ACC_W-1:0] LIM_NEG =
    -nrlp_pkg::ACC_W'(nrlp_pkg::NUM_LIMIT);

  assign is_digit = char_i inside {[nrlp_pkg::CHAR_ZERO:nrlp_pkg::CHAR_NINE]};
  assign digit    = 4'(char_i - nrlp_pkg::CHAR_ZERO);
  assign acc_ext  = nrlp_pkg::ACC_W'(scan_i.acc);
  assign acc10    = acc_ext * nrlp_pkg::ACC_W'(10);
  assign sum_pos  = acc10 + nrlp_pkg::ACC_W'(digit);
  assign sum_neg  = acc10 - nrlp_pkg::ACC_W'(digit);

  always_comb begin
    scan_o = scan_i;
    if (scan_i.phase == nrlp_pkg::PH_SPACES && char_i == nrlp_pkg::CHAR_SPACE) begin
      scan_o = scan_i;
    end else if (scan_i.phase == nrlp_pkg::PH_SPACES &&
                 (char_i == nrlp_pkg::CHAR_PLUS || char_i == nrlp_pkg::CHAR_MINUS)) begin
      scan_o.phase = (char_i == nrlp_pkg::CHAR_MINUS) ? nrlp_pkg::PH_NEG : nrlp_pkg::PH_POS;
    end else if (scan_i.phase != nrlp_pkg::PH_STOPPED && is_digit) begin
      if (scan_i.phase == nrlp_pkg::PH_NEG) begin
        scan_o.acc = (sum_neg < LIM_NEG) ? LIM_NEG[nrlp_pkg::VAL_W-1:0]
                                         : sum_neg[nrlp_pkg::VAL_W-1:0];
      end else begin
        scan_o.phase = nrlp_pkg::PH_POS;
        scan_o.acc   = (sum_pos > LIM_POS) ? LIM_POS[nrlp_pkg::VAL_W-1:0]
                                           : sum_pos[nrlp_pkg::VAL_W-1:0];
      end
    end else begin
      scan_o.phase = nrlp_pkg::PH_STOPPED;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the NMEA RMC line parser core
// Feeds directed and random GPS receiver bytes into the parser one beat at a
// time, works out the line report that each carriage return must give, and
// checks every report beat field by field against the oldest one pending.
// ----------------------------------------------------------------------------
module tb;
  import nrlp_pkg::*;

  localparam int TOTAL_BYTES  = 1850;
  localparam int TAIL_BYTES   = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 20;
  localparam int WATCHDOG_MAX = 6000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    line_class_t             cls;
    fix_state_t              fix;
    logic signed [VAL_W-1:0] lat;
    logic [7:0]              lat_hem;
    logic signed [VAL_W-1:0] lon;
    logic [7:0]              lon_hem;
  } line_report_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [7:0]   pending_q[$];
  line_report_t report_q[$];

  int         line_len;
  int         commas;
  int         head_hits;
  logic [7:0] status_ch;
  num_phase_t scan_phase;
  int         lat_acc;
  int         lon_acc;
  logic [7:0] lat_dir;
  logic [7:0] lon_dir;
  fix_state_t fix_now;
  int         held_lat;
  int         held_lon;
  logic [7:0] held_lat_dir;
  logic [7:0] held_lon_dir;
  string      rmc_tag = "$GPRMC";

  int bytes_taken   = 0;
  int reports_seen  = 0;
  int mismatches    = 0;
  int fix_lines     = 0;
  int nofix_lines   = 0;
  int ignored_lines = 0;
  int tx_gap        = 0;
  int rx_gap        = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  bit tail_part     = 1'b0;
  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;
  bit hold_done     = 1'b0;
  bit noise_on      = 1'b0;

  line_report_t got_rep;

  nmea_rmc_line_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic clear_line_state();
    line_len   = 0;
    commas     = 0;
    head_hits  = 0;
    status_ch  = 8'd0;
    scan_phase = PH_SPACES;
    lat_acc    = 0;
    lon_acc    = 0;
    lat_dir    = 8'd0;
    lon_dir    = 8'd0;
  endtask

  task automatic scan_char(input logic [7:0] c, inout int acc);
    int digit;
    if (scan_phase == PH_SPACES && c == CHAR_SPACE) begin
    end else if (scan_phase == PH_SPACES && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      scan_phase = (c == CHAR_MINUS) ? PH_NEG : PH_POS;
    end else if (scan_phase != PH_STOPPED && c >= CHAR_ZERO && c <= CHAR_NINE) begin
      digit = int'(c) - int'(CHAR_ZERO);
      if (scan_phase == PH_NEG) begin
        acc = acc * 10 - digit;
        if (acc < -NUM_LIMIT) acc = -NUM_LIMIT;
      end else begin
        scan_phase = PH_POS;
        acc = acc * 10 + digit;
        if (acc > NUM_LIMIT) acc = NUM_LIMIT;
      end
    end else begin
      scan_phase = PH_STOPPED;
    end
  endtask

  task automatic absorb_byte(input logic [7:0] c);
    line_report_t rep;
    if (c >= CHAR_PRINT_MIN) begin
      if (line_len < LINE_CHARS_DEF - 1) begin
        line_len++;
        if (c == CHAR_COMMA) begin
          if (commas < COMMA_CAP) commas++;
          scan_phase = PH_SPACES;
        end else begin
          case (commas)
            FIELD_HEAD: begin
              if (head_hits < HEAD_LEN && c == rmc_tag[head_hits]) head_hits++;
              else head_hits = HEAD_FAIL;
            end
            FIELD_STATUS: begin
              if (status_ch == 8'd0) status_ch = c;
            end
            FIELD_LAT: scan_char(c, lat_acc);
            FIELD_LAT_DIR: begin
              if (lat_dir == 8'd0) lat_dir = c;
            end
            FIELD_LON: scan_char(c, lon_acc);
            FIELD_LON_DIR: begin
              if (lon_dir == 8'd0) lon_dir = c;
            end
            default: ;
          endcase
        end
      end
    end else if (c == CHAR_CR) begin
      rep.cls = CLS_IGNORED;
      if (head_hits == HEAD_LEN && commas >= MIN_COMMAS) begin
        if (status_ch == CHAR_LOCK) begin
          rep.cls      = CLS_FIX;
          fix_now      = FIX_LOCKED;
          held_lat     = lat_acc;
          held_lon     = lon_acc;
          held_lat_dir = lat_dir;
          held_lon_dir = lon_dir;
        end else begin
          rep.cls = CLS_NO_FIX;
          fix_now = FIX_NOT_LOCKED;
        end
      end
      rep.fix     = fix_now;
      rep.lat     = VAL_W'(held_lat);
      rep.lat_hem = held_lat_dir;
      rep.lon     = VAL_W'(held_lon);
      rep.lon_hem = held_lon_dir;
      report_q.push_back(rep);
      if (rep.cls == CLS_FIX) fix_lines++;
      else if (rep.cls == CLS_NO_FIX) nofix_lines++;
      else ignored_lines++;
      clear_line_state();
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(32, 255));
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int v;
    if (noise_on && $urandom_range(0, 39) == 0) begin
      v = $urandom_range(0, 31);
      if (v == CHAR_CR) v = 0;
      pending_q.push_back(8'(v));
    end
    pending_q.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    push_byte(CHAR_CR);
  endtask

  task automatic push_number();
    int n;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(CHAR_SPACE);
    n = $urandom_range(0, 5);
    if (n == 0) push_byte(CHAR_PLUS);
    else if (n == 1) push_byte(CHAR_MINUS);
    n = ($urandom_range(0, 6) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
    repeat (n) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    n = $urandom_range(0, 3);
    if (n == 0) begin
      push_text(".");
      repeat ($urandom_range(1, 4)) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end else if (n == 1) begin
      push_byte(rand_printable());
    end
  endtask

  task automatic push_dir(input logic [7:0] one, input logic [7:0] other);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) push_byte(one);
    else if (r < 7) push_byte(other);
    else if (r == 8) push_byte(rand_printable());
    else if (r == 9) begin
      push_byte(one);
      push_byte(rand_printable());
    end
  endtask

  task automatic push_sentence(input bit overlong);
    int last_field;
    int r;
    last_field = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 14);
    for (int f = 0; f <= last_field; f++) begin
      if (f > 0) push_byte(CHAR_COMMA);
      case (f)
        FIELD_HEAD: begin
          r = $urandom_range(0, 11);
          if (r < 9) push_text("$GPRMC");
          else if (r == 9) push_text("$GPGGA");
          else if (r == 10) push_text("$GPRM");
          else begin
            push_text("$GPRMC");
            push_byte(rand_printable());
          end
        end
        FIELD_STATUS: begin
          r = $urandom_range(0, 9);
          if (r < 6) push_byte(CHAR_LOCK);
          else if (r < 8) push_text("V");
          else if (r == 9) push_byte(rand_printable());
          if ($urandom_range(0, 4) == 0) push_byte(rand_printable());
        end
        FIELD_LAT, FIELD_LON: push_number();
        FIELD_LAT_DIR: push_dir("N", "S");
        FIELD_LON_DIR: push_dir("E", "W");
        default: begin
          repeat ($urandom_range(0, 6)) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
      endcase
    end
    if (overlong) repeat ($urandom_range(110, 160)) push_byte(rand_printable());
    push_byte(CHAR_CR);
  endtask

  // Stimulus: directed lines first, then random sentences and noise.
  initial begin
    int r;
    push_byte(CHAR_CR);
    push_line("$GPRMC,,V,,,,");
    push_line("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4");
    push_line("$GPRMC,,A,  -0123,S,+999999999,W");
    push_line("$GPRMC,,A,-99999999,,x5,,");
    push_line("$GPRMC,,,12,N,34,E");
    push_line("$GPRMC,,VA,12,N,34,E");
    push_line("$GPRMC,,AV, 1 2,NS,+-5,EW");
    push_line("$GPRMC,,A,12-3,N,- 7,E");
    push_line("$GPRMD,,A,1,N,2,E");
    push_line("$GPRMCX,,A,1,N,2,E");
    push_line("$GPRM,,A,1,N,2,E");
    push_line(" $GPRMC,,A,1,N,2,E");
    push_line("$GPRMC,,A,1,N,2");
    push_line("$GPRMC,,A,99999,N,-99999,E,,,,,,,,,,,,,,,,,,,,,,,,");
    push_text("$GPRMC,,A,77,");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h1F);
    push_text(",88,");
    push_byte(8'h80);
    push_byte(8'h0A);
    push_line(",1");
    push_text("$GPRMC,,A,31,N,42");
    repeat (LINE_CHARS_DEF - 2 - 17) push_byte("z");
    push_line(",,,W");
    push_text("$GPRMC,,A,31,N,42");
    repeat (LINE_CHARS_DEF - 1 - 17) push_byte("z");
    push_line(",W");
    noise_on = 1'b1;
    while (pending_q.size() < TOTAL_BYTES) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        push_sentence($urandom_range(0, 19) == 0);
      end else begin
        repeat ($urandom_range(0, 30)) begin
          r = $urandom_range(0, 255);
          if (r == CHAR_CR) r = 0;
          push_byte(8'(r));
        end
        push_byte(CHAR_CR);
      end
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_tvalid) @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d bytes and %0d line reports", bytes_taken, reports_seen);
    $display("(%0d with fix, %0d without, %0d ignored); receiver held off %0d cycles once.",
             fix_lines, nofix_lines, ignored_lines, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
      tail_part <= 1'b0;
      tx_quiet  <= 1'b0;
      rx_quiet  <= 1'b0;
      clear_line_state();
      fix_now      = FIX_NONE;
      held_lat     = 0;
      held_lon     = 0;
      held_lat_dir = 8'd0;
      held_lon_dir = 8'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata);
        bytes_taken++;
      end
      tail_part <= pending_q.size() < TAIL_BYTES;
      tx_quiet  <= (bytes_taken / 256) % 3 == 2;
      rx_quiet  <= (bytes_taken / 256) % 3 == 1;
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap    <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_tdata  <= pending_q.pop_front();
          in_tvalid <= 1'b1;
          if (!tail_part && !tx_quiet && $urandom_range(0, 9) == 0) begin
            tx_gap <= $urandom_range(1, 13);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && reports_seen >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if (!tail_part && !rx_quiet && $urandom_range(0, 7) == 0) begin
      rx_gap     <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen <= reports_seen + 1;
      if (report_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected nothing, actual tuser %0d tdata %h",
                 $time, out_tuser, out_tdata);
      end else begin
        got_rep = report_q.pop_front();
        check_field("line_class", got_rep.cls, out_tuser);
        check_field("fix_state", got_rep.fix, out_tdata[1:0]);
        check_field("latitude_ddmm", $signed(got_rep.lat), $signed(out_tdata[19:2]));
        check_field("latitude_hemisphere", got_rep.lat_hem, out_tdata[27:20]);
        check_field("longitude_dddmm", $signed(got_rep.lon), $signed(out_tdata[45:28]));
        check_field("longitude_hemisphere", got_rep.lon_hem, out_tdata[53:46]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_MAX);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
